// ===== rtl/core/tss_pkg.sv =====
`default_nettype none

package tss_pkg;

   // Result action codes.
   typedef enum logic [2:0] {
      ACT_IGNORE = 3'd0,
      ACT_RESET  = 3'd1,
      ACT_CLOSE  = 3'd2,
      ACT_APPEND = 3'd3,
      ACT_FULL   = 3'd4
   } action_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_UPDATE = 2'd2
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic lookup;
      logic update;
   } cmd_type;

   // Widths of the stream key parts and of the other request and result fields.
   localparam int unsigned ADDRS_W = 64;
   localparam int unsigned PORTS_W = 32;
   localparam int unsigned SEQ_W   = 32;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned OUT_SLOT_W = 4;

endpackage

`default_nettype wire

// ===== rtl/core/tss_ctrl.sv =====
`default_nettype none

module tss_ctrl
   import tss_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd,
   output logic         rsp_valid
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;

   // The block is only unable to take a request while the lookup runs.
   assign busy   = (state_ff == ST_LOOKUP);
   assign accept = start && !busy;

   // State register and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_UPDATE);
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd.load_req = accept;
      cmd.lookup   = 1'b0;
      cmd.update   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = accept ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // A lookup only ever follows an accepted request.
   a_lookup_after_accept: assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(start && !busy))
      else $error("lookup without an accepted request");

   // An accepted request always starts a lookup.
   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start a lookup");

   // Every lookup is followed by exactly one table update.
   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      busy |=> (cmd.update && !busy))
      else $error("lookup not followed by an update");

   // Each result strobe comes from one update cycle.
   a_strobe_from_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.update))
      else $error("result strobe without an update");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tss_dpath.sv =====
`default_nettype none

module tss_dpath
   import tss_pkg::*;
#(
   parameter int unsigned STREAM_SLOTS = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic                  req_is_tcp,
   input  wire logic [31:0]           req_src_addr,
   input  wire logic [31:0]           req_dst_addr,
   input  wire logic [15:0]           req_src_port,
   input  wire logic [15:0]           req_dst_port,
   input  wire logic [SEQ_W-1:0]      req_seq_number,
   input  wire logic                  req_syn_flag,
   input  wire logic                  req_fin_flag,
   input  wire logic                  req_rst_flag,
   input  wire logic [LEN_W-1:0]      req_payload_length,
   output logic [2:0]                 rsp_action,
   output logic [OUT_SLOT_W-1:0]      rsp_stream_slot,
   output logic [LEN_W-1:0]           rsp_append_length,
   output logic [SEQ_W-1:0]           rsp_expected_seq
);

   localparam int unsigned SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
   localparam int unsigned EXT_W  = (SLOT_W > OUT_SLOT_W) ? SLOT_W : OUT_SLOT_W;

   // Registered request.
   logic               tcp_ff;
   logic [ADDRS_W-1:0] addrs_ff;
   logic [PORTS_W-1:0] ports_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic               syn_ff;
   logic               fin_ff;
   logic               rst_ff;
   logic [LEN_W-1:0]   len_ff;

   // Stream table: one key comparator per entry.
   logic [STREAM_SLOTS-1:0] valid_ff;
   logic [ADDRS_W-1:0]      key_addrs_ff [STREAM_SLOTS];
   logic [PORTS_W-1:0]      key_ports_ff [STREAM_SLOTS];
   logic [SEQ_W-1:0]        next_seq_ff  [STREAM_SLOTS];
   logic [STREAM_SLOTS-1:0] hit_ff;
   logic [STREAM_SLOTS-1:0] hit_in;

   // Update decision.
   logic              found;
   logic [SLOT_W-1:0] hit_idx;
   logic              has_free;
   logic [SLOT_W-1:0] free_idx;
   logic [SLOT_W-1:0] slot;
   logic [EXT_W-1:0]  slot_ext;
   logic [SEQ_W-1:0]  cur_next;
   logic [SEQ_W-1:0]  seq_plus1;
   logic [SEQ_W-1:0]  appended;
   logic              wr_key;
   logic              wr_next;
   logic              wr_valid;
   logic              valid_val;
   logic [SEQ_W-1:0]  next_val;
   action_type        act;
   logic [SEQ_W-1:0]  exp_val;
   logic [LEN_W-1:0]  app_len;

   // Result registers.
   action_type             act_ff;
   logic [OUT_SLOT_W-1:0]  out_slot_ff;
   logic [LEN_W-1:0]       app_len_ff;
   logic [SEQ_W-1:0]       exp_ff;

   // Capture the request when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         tcp_ff   <= req_is_tcp;
         addrs_ff <= {req_src_addr, req_dst_addr};
         ports_ff <= {req_src_port, req_dst_port};
         seq_ff   <= req_seq_number;
         syn_ff   <= req_syn_flag;
         fin_ff   <= req_fin_flag;
         rst_ff   <= req_rst_flag;
         len_ff   <= req_payload_length;
      end
   end

   // Key compare in every entry.
   always_comb begin
      for (int i = 0; i < STREAM_SLOTS; i++) begin
         hit_in[i] = valid_ff[i] && (key_addrs_ff[i] == addrs_ff)
                     && (key_ports_ff[i] == ports_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) hit_ff <= hit_in;
   end

   // Lowest matching entry and lowest free entry.
   always_comb begin
      found    = 1'b0;
      hit_idx  = '0;
      has_free = 1'b0;
      free_idx = '0;
      for (int i = STREAM_SLOTS - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            found   = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // Decide the action and the table writes.
   always_comb begin
      slot      = found ? hit_idx : free_idx;
      seq_plus1 = seq_ff + SEQ_W'(1);
      cur_next  = found ? next_seq_ff[slot] : (syn_ff ? seq_plus1 : seq_ff);
      appended  = cur_next + SEQ_W'(len_ff);
      wr_key    = 1'b0;
      wr_next   = 1'b0;
      wr_valid  = 1'b0;
      valid_val = 1'b1;
      next_val  = cur_next;
      act       = ACT_IGNORE;
      exp_val   = '0;
      app_len   = '0;
      slot_ext  = '0;
      if (!tcp_ff) begin
         act = ACT_IGNORE;
      end else if (!found && !syn_ff && (len_ff == '0)) begin
         act = ACT_IGNORE;
      end else if (!found && !has_free) begin
         act = ACT_FULL;
      end else begin
         slot_ext = EXT_W'(slot);
         // A new stream takes the free entry.
         if (!found) begin
            wr_key   = 1'b1;
            wr_next  = 1'b1;
            wr_valid = 1'b1;
         end
         if (syn_ff || (cur_next == '0)) begin
            act      = ACT_RESET;
            wr_next  = 1'b1;
            next_val = seq_plus1;
            exp_val  = seq_plus1;
         end else if (fin_ff || rst_ff) begin
            act       = ACT_CLOSE;
            wr_valid  = 1'b1;
            valid_val = 1'b0;
         end else if (seq_ff == cur_next) begin
            act      = ACT_APPEND;
            wr_next  = 1'b1;
            next_val = appended;
            exp_val  = appended;
            app_len  = len_ff;
         end else begin
            act     = ACT_IGNORE;
            exp_val = cur_next;
         end
      end
   end

   // Table valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.update && wr_valid) begin
         valid_ff[slot] <= valid_val;
      end
   end

   // Table keys and expected sequence numbers.
   always_ff @(posedge clock) begin
      if (cmd.update && wr_key) begin
         key_addrs_ff[slot] <= addrs_ff;
         key_ports_ff[slot] <= ports_ff;
      end
      if (cmd.update && wr_next) begin
         next_seq_ff[slot] <= next_val;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         act_ff      <= act;
         out_slot_ff <= slot_ext[OUT_SLOT_W-1:0];
         app_len_ff  <= app_len;
         exp_ff      <= exp_val;
      end
   end

   assign rsp_action        = act_ff;
   assign rsp_stream_slot   = out_slot_ff;
   assign rsp_append_length = app_len_ff;
   assign rsp_expected_seq  = exp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tcp_stream_sequence_tracker.sv =====
`default_nettype none

// TCP stream sequence tracker. Each request is one parsed segment descriptor;
// the block looks its 4-tuple up in a table of STREAM_SLOTS streams and
// returns exactly one result telling the consumer to clear the stream's
// buffer, append the payload, drop the segment, or that the stream closed or
// the table is full. A request is taken when start is high and busy is low.
// Each request has a lookup step, the parallel key compare in all entries,
// and an update step, the entry selection and table update. Busy is high
// only during the compare, so a new request can be taken during the update
// of the last one. The result appears on the rsp_ ports with rsp_valid high
// for one cycle, the cycle after the update; the receiver cannot stall it.

module tcp_stream_sequence_tracker
   import tss_pkg::*;
#(
   parameter int unsigned STREAM_SLOTS = 16
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic         req_is_tcp,
   input  wire logic [31:0]  req_src_addr,
   input  wire logic [31:0]  req_dst_addr,
   input  wire logic [15:0]  req_src_port,
   input  wire logic [15:0]  req_dst_port,
   input  wire logic [31:0]  req_seq_number,
   input  wire logic         req_syn_flag,
   input  wire logic         req_fin_flag,
   input  wire logic         req_rst_flag,
   input  wire logic [15:0]  req_payload_length,
   output logic              rsp_valid,
   output logic [2:0]        rsp_action,
   output logic [3:0]        rsp_stream_slot,
   output logic [15:0]       rsp_append_length,
   output logic [31:0]       rsp_expected_seq
);

   cmd_type cmd;

   // Sequencing of the lookup and update cycles.
   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // Stream table and update logic.
   tss_dpath #(
      .STREAM_SLOTS (STREAM_SLOTS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_is_tcp         (req_is_tcp),
      .req_src_addr       (req_src_addr),
      .req_dst_addr       (req_dst_addr),
      .req_src_port       (req_src_port),
      .req_dst_port       (req_dst_port),
      .req_seq_number     (req_seq_number),
      .req_syn_flag       (req_syn_flag),
      .req_fin_flag       (req_fin_flag),
      .req_rst_flag       (req_rst_flag),
      .req_payload_length (req_payload_length),
      .rsp_action         (rsp_action),
      .rsp_stream_slot    (rsp_stream_slot),
      .rsp_append_length  (rsp_append_length),
      .rsp_expected_seq   (rsp_expected_seq)
   );

endmodule

`default_nettype wire

// ===== tb/tcp_stream_sequence_tracker_test.sv =====
`timescale 1ns / 1ps

module tcp_stream_sequence_tracker_test
   import tss_pkg::*;
;

   localparam int STREAM_SLOTS = 16;
   localparam int KEY_POOL     = 20;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   // One parsed segment descriptor, in port order.
   typedef struct packed {
      logic        is_tcp;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq;
      logic        syn;
      logic        fin;
      logic        rst;
      logic [15:0] len;
   } segment_type;

   // One tracker verdict, in port order.
   typedef struct packed {
      action_type  action;
      logic [3:0]  slot;
      logic [15:0] append_length;
      logic [31:0] expected_seq;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_is_tcp = 1'b0;
   logic [31:0] req_src_addr = '0;
   logic [31:0] req_dst_addr = '0;
   logic [15:0] req_src_port = '0;
   logic [15:0] req_dst_port = '0;
   logic [31:0] req_seq_number = '0;
   logic        req_syn_flag = 1'b0;
   logic        req_fin_flag = 1'b0;
   logic        req_rst_flag = 1'b0;
   logic [15:0] req_payload_length = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_action;
   logic [3:0]  rsp_stream_slot;
   logic [15:0] rsp_append_length;
   logic [31:0] rsp_expected_seq;

   tcp_stream_sequence_tracker #(
      .STREAM_SLOTS(STREAM_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_is_tcp(req_is_tcp),
      .req_src_addr(req_src_addr),
      .req_dst_addr(req_dst_addr),
      .req_src_port(req_src_port),
      .req_dst_port(req_dst_port),
      .req_seq_number(req_seq_number),
      .req_syn_flag(req_syn_flag),
      .req_fin_flag(req_fin_flag),
      .req_rst_flag(req_rst_flag),
      .req_payload_length(req_payload_length),
      .rsp_valid(rsp_valid),
      .rsp_action(rsp_action),
      .rsp_stream_slot(rsp_stream_slot),
      .rsp_append_length(rsp_append_length),
      .rsp_expected_seq(rsp_expected_seq)
   );

   // Free-running clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Segments waiting to be sent and verdicts waiting for their result.
   segment_type segment_q[$];
   verdict_type pending_verdicts[$];

   // The tracker's stream table as the testbench sees it.
   logic        trk_valid [STREAM_SLOTS] = '{default: 1'b0};
   logic [63:0] trk_addrs [STREAM_SLOTS];
   logic [31:0] trk_ports [STREAM_SLOTS];
   logic [31:0] trk_next  [STREAM_SLOTS];

   int error_count   = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int cycle_count   = 0;
   int action_seen [8] = '{default: 0};

   // Applies one accepted segment to the stream table and returns its verdict.
   function automatic verdict_type track_segment(segment_type s);
      verdict_type v;
      int hit;
      int free_slot;
      v.action = ACT_IGNORE;
      v.slot = '0;
      v.append_length = '0;
      v.expected_seq = '0;
      hit = -1;
      free_slot = -1;
      if (!s.is_tcp) begin
         return v;
      end
      for (int i = 0; i < STREAM_SLOTS; i++) begin
         if (hit < 0 && trk_valid[i] && trk_addrs[i] == {s.src_addr, s.dst_addr} &&
             trk_ports[i] == {s.src_port, s.dst_port}) begin
            hit = i;
         end
      end
      // An unknown stream is opened only by SYN or by payload.
      if (hit < 0) begin
         if (!s.syn && s.len == 16'd0) begin
            return v;
         end
         for (int i = 0; i < STREAM_SLOTS; i++) begin
            if (free_slot < 0 && !trk_valid[i]) begin
               free_slot = i;
            end
         end
         if (free_slot < 0) begin
            v.action = ACT_FULL;
            return v;
         end
         hit = free_slot;
         trk_valid[hit] = 1'b1;
         trk_addrs[hit] = {s.src_addr, s.dst_addr};
         trk_ports[hit] = {s.src_port, s.dst_port};
         trk_next[hit] = s.syn ? s.seq + 32'd1 : s.seq;
      end
      v.slot = 4'(hit);
      if (s.syn || trk_next[hit] == 32'd0) begin
         trk_next[hit] = s.seq + 32'd1;
         v.action = ACT_RESET;
         v.expected_seq = trk_next[hit];
      end else if (s.fin || s.rst) begin
         trk_valid[hit] = 1'b0;
         v.action = ACT_CLOSE;
      end else if (s.seq == trk_next[hit]) begin
         trk_next[hit] = trk_next[hit] + 32'(s.len);
         v.action = ACT_APPEND;
         v.append_length = s.len;
         v.expected_seq = trk_next[hit];
      end else begin
         v.expected_seq = trk_next[hit];
      end
      return v;
   endfunction

   // Payload lengths weighted toward typical segment sizes.
   function automatic logic [15:0] random_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 10) return 16'd0;
      if (p < 20) return 16'($urandom_range(0, 65535));
      if (p < 23) return 16'hFFFF;
      return 16'($urandom_range(1, 1460));
   endfunction

   // Sequence numbers, some of them close to wrapping.
   function automatic logic [31:0] random_seq();
      if ($urandom_range(0, 9) == 0) begin
         return 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
      end
      return $urandom;
   endfunction

   // Request driver: bursts of requests separated by random gaps.
   segment_type req_cur = '0;
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : drive_requests
      logic start_next;
      start_next = start;
      if (reset) begin
         start_next = 1'b0;
      end else begin
         if (start && !busy) begin
            start_next = 1'b0;
         end
         if (!start_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (segment_q.size() > 0) begin
               req_cur = segment_q.pop_front();
               start_next = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
      end
      start <= start_next;
      req_is_tcp <= req_cur.is_tcp;
      req_src_addr <= req_cur.src_addr;
      req_dst_addr <= req_cur.dst_addr;
      req_src_port <= req_cur.src_port;
      req_dst_port <= req_cur.dst_port;
      req_seq_number <= req_cur.seq;
      req_syn_flag <= req_cur.syn;
      req_fin_flag <= req_cur.fin;
      req_rst_flag <= req_cur.rst;
      req_payload_length <= req_cur.len;
   end

   // Result monitor. Results are checked first, then an accepted request is
   // predicted, so both happen in a fixed order at each edge.
   always @(posedge clock) begin : check_results
      verdict_type got;
      verdict_type want;
      segment_type seen;
      if (!reset) begin
         if (rsp_valid) begin
            got.action = action_type'(rsp_action);
            got.slot = rsp_stream_slot;
            got.append_length = rsp_append_length;
            got.expected_seq = rsp_expected_seq;
            action_seen[rsp_action]++;
            if (pending_verdicts.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("Unexpected result: action %0d slot %0d length %0d seq %h",
                           rsp_action, rsp_stream_slot, rsp_append_length, rsp_expected_seq);
               end
            end else begin
               want = pending_verdicts.pop_front();
               checked_count++;
               if (got !== want) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("Mismatch on result %0d: expected action %0d slot %0d length %0d seq %h",
                              checked_count, want.action, want.slot, want.append_length,
                              want.expected_seq);
                     $display("   got action %0d slot %0d length %0d seq %h",
                              rsp_action, rsp_stream_slot, rsp_append_length, rsp_expected_seq);
                  end
               end
            end
         end
         if (start && !busy) begin
            seen = {req_is_tcp, req_src_addr, req_dst_addr, req_src_port, req_dst_port,
                    req_seq_number, req_syn_flag, req_fin_flag, req_rst_flag,
                    req_payload_length};
            pending_verdicts.push_back(track_segment(seen));
            accepted_count++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_verdicts.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Pool of stream keys used by the random part.
   logic [31:0] key_src  [KEY_POOL];
   logic [31:0] key_dst  [KEY_POOL];
   logic [15:0] key_sp   [KEY_POOL];
   logic [15:0] key_dp   [KEY_POOL];
   logic        gen_open [KEY_POOL];
   logic [31:0] gen_next [KEY_POOL];

   initial begin : stimulus
      segment_type s;
      int k;
      int p;
      int counted;

      for (int i = 0; i < KEY_POOL; i++) begin
         key_src[i] = $urandom;
         key_dst[i] = $urandom;
         key_sp[i] = 16'($urandom);
         key_dp[i] = 16'($urandom);
         gen_open[i] = 1'b0;
         gen_next[i] = '0;
      end

      // Directed part. A non-TCP request with every field at its maximum.
      segment_q.push_back('{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF});
      // All-zero key: unknown stream without SYN or payload is dropped.
      segment_q.push_back('{1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 32'd5, 1'b0, 1'b0, 1'b0, 16'd0});
      // SYN at the top of the sequence space leaves an expected value of zero.
      segment_q.push_back('{1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF,
                            1'b0 | 1'b1, 1'b0, 1'b0, 16'd0});
      // An expected value of zero forces a stream reset.
      segment_q.push_back('{1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 16'd100});
      // In-order segment with the largest payload.
      segment_q.push_back('{1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 32'd1, 1'b0, 1'b0, 1'b0, 16'hFFFF});
      // Out-of-order segment on a known stream.
      segment_q.push_back('{1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 32'd7, 1'b0, 1'b0, 1'b0, 16'd10});
      // All-ones key opened by payload alone; expected wraps past zero.
      segment_q.push_back('{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 16'h0200});
      // New stream carrying FIN is opened and closed in one step.
      segment_q.push_back('{1'b1, 32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80,
                            32'd1234, 1'b0, 1'b1, 1'b0, 16'd10});
      // Close the two directed streams, by RST and by FIN.
      segment_q.push_back('{1'b1, 32'd0, 32'd0, 16'd0, 16'd0, 32'd9, 1'b0, 1'b0, 1'b1, 16'd0});
      segment_q.push_back('{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            32'h100, 1'b0, 1'b1, 1'b0, 16'd0});
      // Fill every slot from the key pool, then one more stream finds the table full.
      for (int i = 0; i <= STREAM_SLOTS; i++) begin
         s = '{1'b1, key_src[i], key_dst[i], key_sp[i], key_dp[i], random_seq(),
               1'b1, 1'b0, 1'b0, 16'd0};
         segment_q.push_back(s);
         if (i < STREAM_SLOTS) begin
            gen_open[i] = 1'b1;
            gen_next[i] = s.seq + 32'd1;
         end
      end

      // Random part: mostly well-formed stream traffic over the key pool.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         p = $urandom_range(0, 99);
         if (p < 5) begin
            s = {1'b0, $urandom, $urandom, 16'($urandom), 16'($urandom), $urandom,
                 3'($urandom), 16'($urandom)};
         end else begin
            k = $urandom_range(0, KEY_POOL - 1);
            s = '{1'b1, key_src[k], key_dst[k], key_sp[k], key_dp[k], random_seq(),
                  1'b0, 1'b0, 1'b0, 16'd0};
            p = $urandom_range(0, 99);
            if (!gen_open[k]) begin
               if (p < 35) begin
                  // Connection setup.
                  s.syn = 1'b1;
                  s.len = ($urandom_range(0, 4) == 0) ? random_length() : 16'd0;
                  gen_open[k] = 1'b1;
                  gen_next[k] = s.seq + 32'd1;
               end else if (p < 50) begin
                  // Mid-stream pickup by payload.
                  s.len = 16'($urandom_range(1, 65535));
                  if ($urandom_range(0, 9) == 0) s.seq = '0;
                  gen_open[k] = 1'b1;
                  gen_next[k] = (s.seq == 32'd0) ? 32'd1 : s.seq + 32'(s.len);
               end else begin
                  // Stray control segment on an unknown stream.
                  s.fin = 1'($urandom_range(0, 1));
                  s.rst = 1'($urandom_range(0, 1));
               end
            end else begin
               s.len = random_length();
               if (p < 62) begin
                  s.seq = gen_next[k];
                  gen_next[k] = (gen_next[k] == 32'd0) ? s.seq + 32'd1
                                                       : gen_next[k] + 32'(s.len);
               end else if (p < 72) begin
                  s.seq = gen_next[k] + 32'($urandom_range(1, 3000));
               end else if (p < 80) begin
                  s.seq = gen_next[k];
                  s.fin = 1'b1;
                  gen_open[k] = 1'b0;
               end else if (p < 84) begin
                  s.rst = 1'b1;
                  gen_open[k] = 1'b0;
               end else if (p < 90) begin
                  s.syn = 1'b1;
                  gen_next[k] = s.seq + 32'd1;
               end else begin
                  // Arbitrary flag mix, sometimes in order.
                  {s.syn, s.fin, s.rst} = 3'($urandom);
                  if ($urandom_range(0, 1) == 0) s.seq = gen_next[k];
                  if (s.syn) begin
                     gen_next[k] = s.seq + 32'd1;
                  end else if (s.fin || s.rst) begin
                     gen_open[k] = 1'b0;
                  end else if (s.seq == gen_next[k]) begin
                     gen_next[k] = gen_next[k] + 32'(s.len);
                  end
               end
            end
         end
         segment_q.push_back(s);
         counted++;
      end

      // Reset, then wait for all requests to go out and all results to come back.
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (segment_q.size() != 0 || start) @(negedge clock);
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d segment descriptors and checked %0d results in %0d cycles.",
               accepted_count, checked_count, cycle_count);
      $display("Results: %0d dropped, %0d resets, %0d closes, %0d appends, %0d table full.",
               action_seen[ACT_IGNORE], action_seen[ACT_RESET], action_seen[ACT_CLOSE],
               action_seen[ACT_APPEND], action_seen[ACT_FULL]);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tss_pkg.sv
rtl/core/tss_ctrl.sv
rtl/core/tss_dpath.sv
rtl/core/tcp_stream_sequence_tracker.sv
tb/tcp_stream_sequence_tracker_test.sv
